@@ rtl/core/char_lcd_shadow_refresh_unit_macros.svh @@
// Assertion macros shared by the character LCD shadow refresh unit.
`ifndef CHAR_LCD_SHADOW_REFRESH_UNIT_MACROS_SVH
`define CHAR_LCD_SHADOW_REFRESH_UNIT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define CLSR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapped implication, checked outside reset.
`define CLSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/clsr_pkg.sv @@
// Types, constants and microcode ROM of the character LCD shadow refresh unit.
package clsr_pkg;

    localparam int DEF_COLUMNS = 16;
    localparam int DEF_LINES   = 2;
    localparam int MAX_RESULTS = 64;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] SPACE_CODE = 8'h20;
    localparam logic [7:0] WAKE_8BIT  = 8'h30;
    localparam logic [7:0] WAKE_4BIT  = 8'h20;
    localparam logic [7:0] CMD_FSET   = 8'h20;
    localparam logic [7:0] CMD_DCTL   = 8'h08;
    localparam logic [7:0] DCTL_ON    = 8'h04;
    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] CMD_HOME   = 8'h02;
    localparam logic [7:0] CMD_DDRAM  = 8'h80;
    localparam logic [7:0] ROW1_OFF   = 8'h40;

    typedef enum logic [1:0] {
        REQ_INIT    = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_REFRESH = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    typedef struct packed {
        t_req       req_type;
        logic       row;
        logic [3:0] col;
        logic [7:0] char_code;
    } t_item;

    typedef struct packed {
        logic       is_data;
        logic       nibble_only;
        logic [7:0] bus_value;
        logic       last;
    } t_result;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DUAL_LINE        = 2'd0;
    localparam t_cfg_idx CFG_TALL_FONT        = 2'd1;
    localparam t_cfg_idx CFG_CURSOR_UNDERLINE = 2'd2;
    localparam t_cfg_idx CFG_BLINK_ON         = 2'd3;

    typedef struct packed {
        logic dual_line;
        logic tall_font;
        logic cursor_underline;
        logic blink_on;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{dual_line: 1'b1, tall_font: 1'b0,
                                   cursor_underline: 1'b1, blink_on: 1'b1};

    typedef logic [NRES_W-1:0] t_nres;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_INIT,
        C_SAME,
        C_LIMIT,
        C_MORE_CELLS,
        C_MORE_COLS,
        C_ROW_BAD
    } t_cond;

    typedef enum logic [3:0] {
        E_NONE,
        E_WAKE8,
        E_WAKE4,
        E_FSET,
        E_DCTL,
        E_DON,
        E_CLEAR,
        E_HOME,
        E_ADDR,
        E_DATA
    } t_emit;

    typedef enum logic [2:0] {
        W_NONE,
        W_REQ_ITEM,
        W_REQ_BLANK,
        W_REQ_BLANK_DIFF,
        W_SHOWN
    } t_wsel;

    typedef enum logic [1:0] {
        P_HOLD,
        P_ZERO,
        P_ITEM_ROW,
        P_INC
    } t_pos;

    typedef logic [4:0] t_upc;

    localparam t_upc U_IDLE     = 5'd0;
    localparam t_upc U_WRITE    = 5'd1;
    localparam t_upc U_CLR0     = 5'd2;
    localparam t_upc U_CLR1     = 5'd3;
    localparam t_upc U_FIN      = 5'd4;
    localparam t_upc U_INIT0    = 5'd5;
    localparam t_upc U_INIT_RD  = 5'd6;
    localparam t_upc U_INIT_CMP = 5'd7;
    localparam t_upc U_WAKE1    = 5'd8;
    localparam t_upc U_WAKE2    = 5'd9;
    localparam t_upc U_WAKE3    = 5'd10;
    localparam t_upc U_WAKE4    = 5'd11;
    localparam t_upc U_FSET     = 5'd12;
    localparam t_upc U_DCTL     = 5'd13;
    localparam t_upc U_DON      = 5'd14;
    localparam t_upc U_CLRA     = 5'd15;
    localparam t_upc U_CLRB     = 5'd16;
    localparam t_upc U_CLRC     = 5'd17;
    localparam t_upc U_HOME     = 5'd18;
    localparam t_upc U_REF0     = 5'd19;
    localparam t_upc U_REF_RD   = 5'd20;
    localparam t_upc U_REF_CMP  = 5'd21;
    localparam t_upc U_REF_LIM  = 5'd22;
    localparam t_upc U_REF_ADR  = 5'd23;
    localparam t_upc U_REF_DAT  = 5'd24;
    localparam t_upc U_REF_NXT  = 5'd25;
    localparam t_upc U_REF_END  = 5'd26;
    localparam t_upc U_LAST     = U_REF_END;

    typedef struct packed {
        t_cond cond;
        t_upc  target;
        t_emit emit;
        t_wsel wsel;
        t_pos  pos;
        logic  flush;
        logic  set_init;
    } t_ctl;

    typedef struct packed {
        logic not_init;
        logic same;
        logic limit;
        logic more_cells;
        logic more_cols;
        logic row_bad;
    } t_stat;

    function automatic t_ctl mk(t_cond c, t_upc t, t_emit e, t_wsel w, t_pos p,
                                logic fl, logic si);
        t_ctl r;
        r.cond     = c;
        r.target   = t;
        r.emit     = e;
        r.wsel     = w;
        r.pos      = p;
        r.flush    = fl;
        r.set_init = si;
        return r;
    endfunction

    function automatic t_ctl ucode(t_upc step);
        t_ctl w;
        w = mk(C_NEVER, U_IDLE, E_NONE, W_NONE, P_HOLD, 1'b0, 1'b0);
        unique case (step)
            U_IDLE:     w = mk(C_NEVER, U_IDLE, E_NONE, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_WRITE:    w = mk(C_ALWAYS, U_IDLE, E_NONE, W_REQ_ITEM, P_HOLD, 1'b0, 1'b0);
            U_CLR0:     w = mk(C_ROW_BAD, U_IDLE, E_NONE, W_NONE, P_ITEM_ROW, 1'b0, 1'b0);
            U_CLR1:     w = mk(C_MORE_COLS, U_CLR1, E_NONE, W_REQ_BLANK, P_INC, 1'b0, 1'b0);
            U_FIN:      w = mk(C_ALWAYS, U_IDLE, E_NONE, W_NONE, P_HOLD, 1'b1, 1'b0);
            U_INIT0:    w = mk(C_NEVER, U_IDLE, E_NONE, W_NONE, P_ZERO, 1'b0, 1'b0);
            U_INIT_RD:  w = mk(C_NEVER, U_IDLE, E_NONE, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_INIT_CMP: w = mk(C_MORE_CELLS, U_INIT_RD, E_NONE, W_REQ_BLANK_DIFF, P_INC,
                               1'b0, 1'b0);
            U_WAKE1:    w = mk(C_NEVER, U_IDLE, E_WAKE8, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_WAKE2:    w = mk(C_NEVER, U_IDLE, E_WAKE8, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_WAKE3:    w = mk(C_NEVER, U_IDLE, E_WAKE8, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_WAKE4:    w = mk(C_NEVER, U_IDLE, E_WAKE4, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_FSET:     w = mk(C_NEVER, U_IDLE, E_FSET, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_DCTL:     w = mk(C_NEVER, U_IDLE, E_DCTL, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_DON:      w = mk(C_NEVER, U_IDLE, E_DON, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_CLRA:     w = mk(C_NEVER, U_IDLE, E_CLEAR, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_CLRB:     w = mk(C_NEVER, U_IDLE, E_CLEAR, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_CLRC:     w = mk(C_NEVER, U_IDLE, E_CLEAR, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_HOME:     w = mk(C_ALWAYS, U_FIN, E_HOME, W_NONE, P_HOLD, 1'b0, 1'b1);
            U_REF0:     w = mk(C_NOT_INIT, U_FIN, E_NONE, W_NONE, P_ZERO, 1'b0, 1'b0);
            U_REF_RD:   w = mk(C_NEVER, U_IDLE, E_NONE, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_REF_CMP:  w = mk(C_SAME, U_REF_NXT, E_NONE, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_REF_LIM:  w = mk(C_LIMIT, U_FIN, E_NONE, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_REF_ADR:  w = mk(C_NEVER, U_IDLE, E_ADDR, W_NONE, P_HOLD, 1'b0, 1'b0);
            U_REF_DAT:  w = mk(C_NEVER, U_IDLE, E_DATA, W_SHOWN, P_HOLD, 1'b0, 1'b0);
            U_REF_NXT:  w = mk(C_MORE_CELLS, U_REF_RD, E_NONE, W_NONE, P_INC, 1'b0, 1'b0);
            U_REF_END:  w = mk(C_ALWAYS, U_FIN, E_NONE, W_NONE, P_HOLD, 1'b0, 1'b0);
            default:    w = mk(C_ALWAYS, U_IDLE, E_NONE, W_NONE, P_HOLD, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

    function automatic t_upc entry(t_req req);
        t_upc e;
        e = U_IDLE;
        unique case (req)
            REQ_INIT:    e = U_INIT0;
            REQ_WRITE:   e = U_WRITE;
            REQ_REFRESH: e = U_REF0;
            REQ_CLEAR:   e = U_CLR0;
            default:     e = U_IDLE;
        endcase
        return e;
    endfunction

endpackage

@@ rtl/core/clsr_seq.sv @@
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`include "char_lcd_shadow_refresh_unit_macros.svh"

module clsr_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  clsr_pkg::t_req   i_req_type,
    input  clsr_pkg::t_stat  i_stat,
    output logic             o_busy,
    output logic             o_accept,
    output clsr_pkg::t_ctl   o_ctl
);

    clsr_pkg::t_upc r_upc;
    clsr_pkg::t_upc n_upc;
    clsr_pkg::t_ctl ctl;
    logic           take;

    assign ctl      = clsr_pkg::ucode(r_upc);
    assign o_ctl    = ctl;
    assign o_busy   = (r_upc != clsr_pkg::U_IDLE);
    assign o_accept = i_start && (r_upc == clsr_pkg::U_IDLE);

    always_comb begin
        take = 1'b0;
        unique case (ctl.cond)
            clsr_pkg::C_NEVER:      take = 1'b0;
            clsr_pkg::C_ALWAYS:     take = 1'b1;
            clsr_pkg::C_NOT_INIT:   take = i_stat.not_init;
            clsr_pkg::C_SAME:       take = i_stat.same;
            clsr_pkg::C_LIMIT:      take = i_stat.limit;
            clsr_pkg::C_MORE_CELLS: take = i_stat.more_cells;
            clsr_pkg::C_MORE_COLS:  take = i_stat.more_cols;
            clsr_pkg::C_ROW_BAD:    take = i_stat.row_bad;
            default:                take = 1'b0;
        endcase
    end

    always_comb begin
        if (r_upc == clsr_pkg::U_IDLE) begin
            n_upc = o_accept ? clsr_pkg::entry(i_req_type) : clsr_pkg::U_IDLE;
        end else if (take) begin
            n_upc = ctl.target;
        end else begin
            n_upc = r_upc + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= clsr_pkg::U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    `CLSR_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, o_accept, o_busy, "accept did not start a program")
    `CLSR_ASSERT(a_upc_range, i_clk, i_rst_n, r_upc <= clsr_pkg::U_LAST, "step counter left the program")

endmodule

@@ rtl/core/clsr_dp.sv @@
// Datapath: character stores, scan position, result hold and output registers.
`include "char_lcd_shadow_refresh_unit_macros.svh"

module clsr_dp #(
    parameter int COLUMNS = clsr_pkg::DEF_COLUMNS,
    parameter int LINES   = clsr_pkg::DEF_LINES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  clsr_pkg::t_item    i_item,
    input  clsr_pkg::t_ctl     i_ctl,
    input  clsr_pkg::t_cfg     i_cfg,
    output clsr_pkg::t_stat    o_stat,
    output logic               o_strobe,
    output clsr_pkg::t_result  o_result
);

    localparam int CELLS = LINES * COLUMNS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic          LAST_ROW = 1'(LINES - 1);
    localparam logic [AW-1:0] ROW1_BASE = AW'(COLUMNS);

    logic [7:0]       r_req_mem   [CELLS];
    logic [7:0]       r_shown_mem [CELLS];
    logic [CELLS-1:0] r_req_vld;
    logic [CELLS-1:0] r_shown_vld;
    logic [7:0]       r_req_q;
    logic [7:0]       r_shown_q;
    logic             r_req_vq;
    logic             r_shown_vq;

    clsr_pkg::t_item   r_item;
    logic              r_init;
    logic              r_row;
    logic [CW-1:0]     r_col;
    logic              r_prev_row;
    logic [CW-1:0]     r_prev_col;
    clsr_pkg::t_nres   r_nres;
    logic              r_hold_vld;
    clsr_pkg::t_result r_hold;
    logic              r_out_stb;
    clsr_pkg::t_result r_out;

    logic [AW-1:0]     pos_addr;
    logic [AW-1:0]     item_addr;
    logic              item_row_ok;
    logic              item_ok;
    logic [7:0]        req_val;
    logic [7:0]        shown_val;
    logic              same;
    logic              addr_need;
    logic              push;
    clsr_pkg::t_result new_res;
    logic              req_we;
    logic [AW-1:0]     req_waddr;
    logic [7:0]        req_wdata;
    logic              shown_we;
    logic [CW:0]       prev_next;

    assign pos_addr    = r_row ? ROW1_BASE + AW'(r_col) : AW'(r_col);
    assign item_addr   = r_item.row ? ROW1_BASE + AW'(r_item.col) : AW'(r_item.col);
    assign item_row_ok = !r_item.row || (LINES > 1);
    assign item_ok     = item_row_ok && (int'(r_item.col) < COLUMNS);

    assign req_val   = r_req_vq ? r_req_q : 8'h00;
    assign shown_val = r_shown_vq ? r_shown_q : 8'h00;
    assign same      = (req_val == shown_val);

    assign prev_next = {1'b0, r_prev_col} + {{CW{1'b0}}, 1'b1};
    assign addr_need = (r_prev_col == '0) || (r_prev_row != r_row)
                    || (prev_next != {1'b0, r_col});

    assign o_stat.not_init   = !r_init;
    assign o_stat.same       = same;
    assign o_stat.limit      = (r_nres > clsr_pkg::t_nres'(clsr_pkg::MAX_RESULTS - 2));
    assign o_stat.more_cells = !((r_row == LAST_ROW) && (r_col == LAST_COL));
    assign o_stat.more_cols  = (r_col != LAST_COL);
    assign o_stat.row_bad    = !item_row_ok;

    always_comb begin
        new_res = '{is_data: 1'b0, nibble_only: 1'b0, bus_value: 8'h00, last: 1'b0};
        push    = 1'b1;
        unique case (i_ctl.emit)
            clsr_pkg::E_NONE:  push = 1'b0;
            clsr_pkg::E_WAKE8: begin
                new_res.nibble_only = 1'b1;
                new_res.bus_value   = clsr_pkg::WAKE_8BIT;
            end
            clsr_pkg::E_WAKE4: begin
                new_res.nibble_only = 1'b1;
                new_res.bus_value   = clsr_pkg::WAKE_4BIT;
            end
            clsr_pkg::E_FSET:  new_res.bus_value = clsr_pkg::CMD_FSET
                                   | {4'b0000, i_cfg.dual_line, i_cfg.tall_font, 2'b00};
            clsr_pkg::E_DCTL:  new_res.bus_value = clsr_pkg::CMD_DCTL
                                   | {6'b000000, i_cfg.cursor_underline, i_cfg.blink_on};
            clsr_pkg::E_DON:   new_res.bus_value = clsr_pkg::CMD_DCTL | clsr_pkg::DCTL_ON
                                   | {6'b000000, i_cfg.cursor_underline, i_cfg.blink_on};
            clsr_pkg::E_CLEAR: new_res.bus_value = clsr_pkg::CMD_CLEAR;
            clsr_pkg::E_HOME:  new_res.bus_value = clsr_pkg::CMD_HOME;
            clsr_pkg::E_ADDR: begin
                push              = addr_need;
                new_res.bus_value = clsr_pkg::CMD_DDRAM
                                  | (r_row ? clsr_pkg::ROW1_OFF : 8'h00)
                                  | {2'b00, 6'(r_col)};
            end
            clsr_pkg::E_DATA: begin
                new_res.is_data   = 1'b1;
                new_res.bus_value = req_val;
            end
            default:           push = 1'b0;
        endcase
    end

    always_comb begin
        req_we    = 1'b0;
        req_waddr = pos_addr;
        req_wdata = clsr_pkg::SPACE_CODE;
        unique case (i_ctl.wsel)
            clsr_pkg::W_NONE:           req_we = 1'b0;
            clsr_pkg::W_REQ_ITEM: begin
                req_we    = item_ok;
                req_waddr = item_addr;
                req_wdata = r_item.char_code;
            end
            clsr_pkg::W_REQ_BLANK:      req_we = 1'b1;
            clsr_pkg::W_REQ_BLANK_DIFF: req_we = !same;
            clsr_pkg::W_SHOWN:          req_we = 1'b0;
            default:                    req_we = 1'b0;
        endcase
    end

    assign shown_we = (i_ctl.wsel == clsr_pkg::W_SHOWN);

    always_ff @(posedge i_clk) begin
        if (req_we) begin
            r_req_mem[req_waddr] <= req_wdata;
        end
        r_req_q <= r_req_mem[pos_addr];
    end

    always_ff @(posedge i_clk) begin
        if (shown_we) begin
            r_shown_mem[pos_addr] <= req_val;
        end
        r_shown_q <= r_shown_mem[pos_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld   <= '0;
            r_shown_vld <= '0;
            r_req_vq    <= 1'b0;
            r_shown_vq  <= 1'b0;
            r_init      <= 1'b0;
            r_nres      <= '0;
            r_hold_vld  <= 1'b0;
            r_out_stb   <= 1'b0;
        end else begin
            if (req_we) begin
                r_req_vld[req_waddr] <= 1'b1;
            end
            if (shown_we) begin
                r_shown_vld[pos_addr] <= 1'b1;
            end
            r_req_vq   <= r_req_vld[pos_addr];
            r_shown_vq <= r_shown_vld[pos_addr];
            if (i_ctl.set_init) begin
                r_init <= 1'b1;
            end
            if (i_ctl.pos == clsr_pkg::P_ZERO) begin
                r_nres <= '0;
            end else if (push) begin
                r_nres <= r_nres + clsr_pkg::t_nres'(1);
            end
            if (push) begin
                r_out_stb  <= r_hold_vld;
                r_hold_vld <= 1'b1;
            end else if (i_ctl.flush) begin
                r_out_stb  <= r_hold_vld;
                r_hold_vld <= 1'b0;
            end else begin
                r_out_stb  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_item;
        end
        unique case (i_ctl.pos)
            clsr_pkg::P_HOLD: ;
            clsr_pkg::P_ZERO: begin
                r_row      <= 1'b0;
                r_col      <= '0;
                r_prev_row <= 1'b0;
                r_prev_col <= '0;
            end
            clsr_pkg::P_ITEM_ROW: begin
                r_row <= r_item.row;
                r_col <= '0;
            end
            clsr_pkg::P_INC: begin
                if (r_col == LAST_COL) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            default: ;
        endcase
        if (shown_we) begin
            r_prev_row <= r_row;
            r_prev_col <= r_col;
        end
        if (push) begin
            r_hold <= new_res;
            r_out  <= r_hold;
        end else if (i_ctl.flush) begin
            r_out <= '{is_data: r_hold.is_data, nibble_only: r_hold.nibble_only,
                       bus_value: r_hold.bus_value, last: 1'b1};
        end
    end

    assign o_strobe = r_out_stb;
    assign o_result = r_out;

    `CLSR_ASSERT_IMP(a_out_from_hold, i_clk, i_rst_n, r_out_stb, $past(r_hold_vld), "stray transfer")
    `CLSR_ASSERT(a_nres_bound, i_clk, i_rst_n, r_nres <= clsr_pkg::t_nres'(clsr_pkg::MAX_RESULTS), "count overflow")
    `CLSR_ASSERT_IMP(a_shown_diff, i_clk, i_rst_n, shown_we, !same, "equal cell shown")

endmodule

@@ rtl/core/char_lcd_shadow_refresh_unit.sv @@
// Top level of the character LCD shadow refresh unit: config registers and core.
//
// channel   | direction | transfer when          | payload
// ----------+-----------+------------------------+-----------------------------
// request   | in        | i_start && !o_busy     | i_item  (clsr_pkg::t_item)
// result    | out       | o_strobe (one cycle)   | o_result (clsr_pkg::t_result)
// config    | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// Each store read takes two microcode steps through the registered read port, and
// no step emits more than one result. Each result waits in a hold register until
// the next result or the final flush moves it to the output register; the last
// one is flagged and shows as o_busy drops. Stores clear at reset via valid bits,
// so no clearing pass is needed. The receiver cannot stall.
module char_lcd_shadow_refresh_unit #(
    parameter int COLUMNS = clsr_pkg::DEF_COLUMNS,
    parameter int LINES   = clsr_pkg::DEF_LINES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  clsr_pkg::t_item     i_item,
    output logic                o_busy,
    output logic                o_strobe,
    output clsr_pkg::t_result   o_result,
    input  logic                i_cfg_we,
    input  clsr_pkg::t_cfg_idx  i_cfg_idx,
    input  logic                i_cfg_data
);

    clsr_pkg::t_cfg  r_cfg;
    clsr_pkg::t_ctl  ctl;
    clsr_pkg::t_stat stat;
    logic            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= clsr_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                clsr_pkg::CFG_DUAL_LINE:        r_cfg.dual_line        <= i_cfg_data;
                clsr_pkg::CFG_TALL_FONT:        r_cfg.tall_font        <= i_cfg_data;
                clsr_pkg::CFG_CURSOR_UNDERLINE: r_cfg.cursor_underline <= i_cfg_data;
                clsr_pkg::CFG_BLINK_ON:         r_cfg.blink_on         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    clsr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_item.req_type),
        .i_stat     (stat),
        .o_busy     (o_busy),
        .o_accept   (accept),
        .o_ctl      (ctl)
    );

    clsr_dp #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .i_cfg    (r_cfg),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
